// File: design/lgd_pkg.sv
// ----------------------------------------------------------------------------
// lgd_pkg: shared types and constants for the luma Gaussian row decimator
// Holds the luma weights, the rounding constants, the register indexes
// and the item format that travels through the front-to-back queue.
// ----------------------------------------------------------------------------
package lgd_pkg;

    // Widths of the luma samples, weights and the column counter.
    localparam int LUMA_W   = 16;
    localparam int WGT_W    = 16;
    localparam int COL_W    = 13;
    localparam int PIX_W    = 8;

    // Queue between front and back.
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    // Luma weights over 256 for red, green and blue.
    localparam logic [LUMA_W-1:0] LUMA_R = 16'd77;
    localparam logic [LUMA_W-1:0] LUMA_G = 16'd151;
    localparam logic [LUMA_W-1:0] LUMA_B = 16'd28;

    // Product and sum widths of the filter datapath.
    localparam int PSUM_W   = LUMA_W + 1;
    localparam int PROD_W   = WGT_W + PSUM_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int OUT_SHIFT = 24;
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (OUT_SHIFT - 1);

    // Reset values of the Q16 tap weights.
    localparam logic [WGT_W-1:0] WGT_OUTER_RST  = 16'd436;
    localparam logic [WGT_W-1:0] WGT_INNER_RST  = 16'd12729;
    localparam logic [WGT_W-1:0] WGT_CENTER_RST = 16'd39206;

    // Register indexes on the configuration port (word address).
    localparam logic [1:0] REG_OUTER  = 2'd0;
    localparam logic [1:0] REG_INNER  = 2'd1;
    localparam logic [1:0] REG_CENTER = 2'd2;

    typedef logic [LUMA_W-1:0] t_luma;

    // Tap weights as seen by the back end.
    typedef struct packed {
        logic [WGT_W-1:0] outer;
        logic [WGT_W-1:0] inner;
        logic [WGT_W-1:0] center;
    } t_weights;

    // One queued item: the window after the pixel was shifted in, entry 4
    // the newest, and what the back end has to produce from it.
    typedef struct packed {
        logic [4:0][LUMA_W-1:0] win;
        logic                   even;
        logic                   has_norm;
        logic                   has_flush;
    } t_job;

endpackage

// File: design/lgd_front.sv
// ----------------------------------------------------------------------------
// lgd_front: pixel intake and classification
// Converts each pixel to luma, keeps the five-sample window and the column
// counter, and queues an item when the pixel causes one or two results.
// ----------------------------------------------------------------------------
module lgd_front import lgd_pkg::*; #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pix_valid,
    output logic              o_pix_ready,
    input  logic [3*PIX_W-1:0] i_rgb,      // red, green, blue from bit 0 up
    input  logic              i_row_end,
    input  logic              i_q_full,
    output logic              o_push,
    output t_job              o_job
);

    localparam logic [COL_W-1:0] COL_LIMIT =
        COL_W'((MAX_ROW_WIDTH > 4) ? (MAX_ROW_WIDTH - 1) : 3);

    logic [4:0][LUMA_W-1:0] r_win;
    logic [4:0][LUMA_W-1:0] n_win;
    logic [COL_W-1:0]       r_col;
    logic [COL_W-1:0]       n_col;
    logic [COL_W:0]         col_inc;
    logic                   accept;
    t_luma                  y;
    logic                   even;
    logic                   has_norm;

    assign o_pix_ready = !i_q_full;
    assign accept      = i_pix_valid && !i_q_full;

    // Luma in Q8: fixed weights over 256.
    assign y = LUMA_R * LUMA_W'(i_rgb[PIX_W-1:0])
             + LUMA_G * LUMA_W'(i_rgb[2*PIX_W-1:PIX_W])
             + LUMA_B * LUMA_W'(i_rgb[3*PIX_W-1:2*PIX_W]);

    // The first pixel of a row fills the whole window (left edge clamp).
    always_comb begin
        if (r_col == '0) begin
            n_win = {5{y}};
        end else begin
            n_win = {y, r_win[4:1]};
        end
    end

    assign even     = !r_col[0];
    assign has_norm = even && (r_col[COL_W-1:1] != '0);
    assign o_push   = accept && (has_norm || i_row_end);

    always_comb begin
        o_job.win       = n_win;
        o_job.even      = even;
        o_job.has_norm  = has_norm;
        o_job.has_flush = i_row_end;
    end

    // Column counter: back to zero at row end, held at its parity past the limit.
    always_comb begin
        col_inc = {1'b0, r_col} + (COL_W+1)'(1);
        if (i_row_end) begin
            n_col = '0;
        end else if (col_inc > {1'b0, COL_LIMIT}) begin
            n_col = COL_W'(col_inc - (COL_W+1)'(2));
        end else begin
            n_col = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (accept) begin
            r_col <= n_col;
        end
    end

    // Window payload needs no reset: column zero always reloads it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LIMIT)
        else $error("column counter beyond its limit");

endmodule

// File: design/lgd_fifo.sv
// ----------------------------------------------------------------------------
// lgd_fifo: short queue between front and back
// Holds pending items so that intake and filtering stall independently.
// ----------------------------------------------------------------------------
module lgd_fifo import lgd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue fill level out of range");

endmodule

// File: design/lgd_back.sv
// ----------------------------------------------------------------------------
// lgd_back: 5-tap filter pipeline
// Expands each queued item into its normal and flushed results, then runs
// pre-add, multiply and round/saturate stages into the output register.
// ----------------------------------------------------------------------------
module lgd_back import lgd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_job             i_job,
    output logic             o_pop,
    input  t_weights         i_weights,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_luma,
    output logic             o_last
);

    logic              en;
    logic              issue;
    logic              norm_job;
    logic              r_norm_done;
    t_luma             ta, tb, tc, td, te;

    logic              r_s1_valid;
    logic              r_s1_last;
    logic [PSUM_W-1:0] r_s1_outer;
    logic [PSUM_W-1:0] r_s1_inner;
    t_luma             r_s1_center;

    logic              r_s2_valid;
    logic              r_s2_last;
    logic [PROD_W-1:0] r_s2_outer;
    logic [PROD_W-1:0] r_s2_inner;
    logic [PROD_W-1:0] r_s2_center;

    logic              r_out_valid;
    logic              r_out_last;
    logic [PIX_W-1:0]  r_out_luma;

    logic [ACC_W-1:0]  acc;
    logic [ACC_W-OUT_SHIFT-1:0] scaled;
    logic [PIX_W-1:0]  sat;

    // The whole pipeline moves when the output register is free or taken.
    assign en       = !r_out_valid || i_ready;
    assign norm_job = i_job.has_norm && !r_norm_done;
    assign issue    = i_q_valid && en;
    assign o_pop    = issue && (!norm_job || !i_job.has_flush);

    // Tap selection: normal result, or the flushed one with the right edge clamped.
    always_comb begin
        if (norm_job) begin
            {te, td, tc, tb, ta} = i_job.win;
        end else if (i_job.even) begin
            ta = i_job.win[2];
            tb = i_job.win[3];
            tc = i_job.win[4];
            td = i_job.win[4];
            te = i_job.win[4];
        end else begin
            ta = i_job.win[1];
            tb = i_job.win[2];
            tc = i_job.win[3];
            td = i_job.win[4];
            te = i_job.win[4];
        end
    end

    // Remembers that the normal result of the head item has gone out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_done <= 1'b0;
        end else if (issue) begin
            r_norm_done <= norm_job && i_job.has_flush;
        end
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Final sum, round half up, saturate.
    assign acc    = ACC_W'(r_s2_outer) + ACC_W'(r_s2_inner) + ACC_W'(r_s2_center)
                  + ROUND_BIAS;
    assign scaled = acc[ACC_W-1:OUT_SHIFT];
    assign sat    = (scaled[ACC_W-OUT_SHIFT-1:PIX_W] != '0) ? '1 : scaled[PIX_W-1:0];

    // Datapath stages: symmetric pre-add, multiply, accumulate.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_last   <= !norm_job;
            r_s1_outer  <= PSUM_W'(ta) + PSUM_W'(te);
            r_s1_inner  <= PSUM_W'(tb) + PSUM_W'(td);
            r_s1_center <= tc;

            r_s2_last   <= r_s1_last;
            r_s2_outer  <= PROD_W'(i_weights.outer)  * PROD_W'(r_s1_outer);
            r_s2_inner  <= PROD_W'(i_weights.inner)  * PROD_W'(r_s1_inner);
            r_s2_center <= PROD_W'(i_weights.center) * PROD_W'(r_s1_center);

            r_out_last  <= r_s2_last;
            r_out_luma  <= sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_luma  = r_out_luma;
    assign o_last  = r_out_last;

    a_norm_done_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_norm_done |-> i_q_valid)
        else $error("normal result marked done without a pending item");

    a_flush_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && !norm_job) |-> o_pop)
        else $error("flushed result issued without retiring its item");

endmodule

// File: design/luma_gauss_decimate_row.sv
// ----------------------------------------------------------------------------
// luma_gauss_decimate_row: RGB-to-luma 5-tap Gaussian row decimator
// Takes one pixel per cycle while the queue has room, emits one filtered
// luma per even column from column 2 on and the flushed last result of each
// row. Q16 tap weights over an APB port.
// Result path: queue, pre-add, multiply, output register. Throughput: one
// pixel per cycle while the queue has room; the pipeline gives one result per
// cycle unless the output stalls, so a two-result row end issues them in turn.
// Reset (synchronous, active low) clears the column counter, the queue,
// the pipeline valids and loads the default weights.
// ----------------------------------------------------------------------------
module luma_gauss_decimate_row import lgd_pkg::*; #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_axis_tlast,   // row_end
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // luma_out [7:0]
    output logic        m_axis_tlast,   // last_of_row
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_weights r_wgt;
    logic     cfg_wr;
    logic     q_full;
    logic     q_push;
    logic     q_valid;
    logic     q_pop;
    t_job     front_job;
    t_job     head_job;

    // Register file: written on the access cycle of an APB write.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wgt.outer  <= WGT_OUTER_RST;
            r_wgt.inner  <= WGT_INNER_RST;
            r_wgt.center <= WGT_CENTER_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_OUTER:  r_wgt.outer  <= pwdata[WGT_W-1:0];
                REG_INNER:  r_wgt.inner  <= pwdata[WGT_W-1:0];
                REG_CENTER: r_wgt.center <= pwdata[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (paddr[3:2])
            REG_OUTER:  prdata = 32'(r_wgt.outer);
            REG_INNER:  prdata = 32'(r_wgt.inner);
            REG_CENTER: prdata = 32'(r_wgt.center);
            default:    prdata = '0;
        endcase
    end

    lgd_front #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (s_axis_tvalid),
        .o_pix_ready (s_axis_tready),
        .i_rgb       (s_axis_tdata),
        .i_row_end   (s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (front_job)
    );

    lgd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    lgd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (q_pop),
        .i_weights (r_wgt),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_luma    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

// File: sim/luma_gauss_decimate_row_test.sv
// ----------------------------------------------------------------------------
// luma_gauss_decimate_row_test: self-checking bench for the luma row decimator
// Streams RGB rows into the block and predicts every filtered, decimated luma
// item from a bit-accurate model of the 5-tap filter kept in a scoreboard.
// Short directed rows come first, then random rows under several tap weight
// settings and idling profiles, and two long output stalls.
// ----------------------------------------------------------------------------

// Predicts the result items of the decimator and checks what the block emits.
class luma_row_scoreboard;

    typedef struct packed {
        logic [7:0] luma;
        logic       last;
    } t_luma_item;

    localparam int COL_LAST = 4095;

    logic [15:0]  w_outer;
    logic [15:0]  w_inner;
    logic [15:0]  w_center;
    logic [15:0]  window [0:4];
    logic [12:0]  column;
    t_luma_item   pending [$];
    int           errors;

    function new();
        w_outer  = lgd_pkg::WGT_OUTER_RST;
        w_inner  = lgd_pkg::WGT_INNER_RST;
        w_center = lgd_pkg::WGT_CENTER_RST;
        for (int k = 0; k < 5; k++) window[k] = '0;
        column = '0;
        errors = 0;
    endfunction

    // Only the low 16 bits of a write land in a weight; unknown indexes drop it.
    function void set_weight(input logic [1:0] index, input logic [31:0] value);
        case (index)
            lgd_pkg::REG_OUTER:  w_outer  = value[15:0];
            lgd_pkg::REG_INNER:  w_inner  = value[15:0];
            lgd_pkg::REG_CENTER: w_center = value[15:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] weight_of(input logic [1:0] index);
        case (index)
            lgd_pkg::REG_OUTER:  return {16'h0, w_outer};
            lgd_pkg::REG_INNER:  return {16'h0, w_inner};
            default:             return {16'h0, w_center};
        endcase
    endfunction

    // Q16 weights times Q8 luma give Q24; round half up and saturate.
    function logic [7:0] filter5(input logic [15:0] a, b, c, d, e);
        logic [63:0] acc;
        acc = 64'(w_outer) * (64'(a) + 64'(e))
            + 64'(w_inner) * (64'(b) + 64'(d))
            + 64'(w_center) * 64'(c);
        acc = (acc + (64'd1 << 23)) >> 24;
        return (acc > 64'd255) ? 8'hFF : acc[7:0];
    endfunction

    function void add_expected(input logic [7:0] luma, input logic last);
        t_luma_item item;
        item.luma = luma;
        item.last = last;
        pending.push_back(item);
    endfunction

    // Tdata holds red in the low byte, then green, then blue.
    function void note_pixel(input logic [23:0] pixel, input logic row_end);
        logic [15:0] y;
        y = lgd_pkg::LUMA_R * pixel[7:0] + lgd_pkg::LUMA_G * pixel[15:8]
          + lgd_pkg::LUMA_B * pixel[23:16];

        // The first pixel of a row fills the window, which clamps the left edge.
        if (column == 0) begin
            for (int k = 0; k < 5; k++) window[k] = y;
        end else begin
            for (int k = 0; k < 4; k++) window[k] = window[k+1];
            window[4] = y;
        end

        if (!column[0] && column >= 2)
            add_expected(filter5(window[0], window[1], window[2], window[3], window[4]),
                         1'b0);

        // The row end flushes the pending result with the last pixel repeated.
        if (row_end) begin
            if (!column[0])
                add_expected(filter5(window[2], window[3], window[4], window[4], window[4]),
                             1'b1);
            else
                add_expected(filter5(window[1], window[2], window[3], window[4], window[4]),
                             1'b1);
            column = '0;
        end else if (column == COL_LAST) begin
            // Past the maximum width the counter stays put but keeps its parity.
            column = 13'(COL_LAST - 1);
        end else begin
            column = column + 1'b1;
        end
    endfunction

    function void check_result(input logic [7:0] luma, input logic last,
                               input longint unsigned now);
        t_luma_item want;
        if (pending.size() == 0) begin
            $display("%0t ns: unexpected item luma %0d last %0b", now, luma, last);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (luma !== want.luma) begin
            $display("%0t ns: luma expected %0d actual %0d", now, want.luma, luma);
            errors++;
        end
        if (last !== want.last) begin
            $display("%0t ns: last_of_row expected %0b actual %0b", now, want.last, last);
            errors++;
        end
    endfunction

endclass

module luma_gauss_decimate_row_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lgd_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red [7:0], green [15:8], blue [23:16]
    logic        s_axis_tlast;   // row_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // luma_out [7:0]
    logic        m_axis_tlast;   // last_of_row
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    luma_row_scoreboard sb;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_started  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    luma_gauss_decimate_row u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check each accepted item, then pick the next tready.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast, $time);
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_started != hold_asked) begin
            hold_started  <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Channels lean toward the extremes now and then.
    function automatic logic [7:0] random_channel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [23:0] random_pixel();
        return {random_channel(), random_channel(), random_channel()};
    endfunction

    // Pure colors, black, white and a mid gray for the directed rows.
    function automatic logic [23:0] corner_pixel(input int n);
        case (n % 6)
            0:       return 24'hFFFFFF;
            1:       return 24'h000000;
            2:       return 24'h0000FF;
            3:       return 24'h00FF00;
            4:       return 24'hFF0000;
            default: return 24'h7F807F;
        endcase
    endfunction

    // Offer one pixel after a random gap and wait until the block takes it.
    task automatic send_pixel(input logic [23:0] pixel, input logic row_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel;
        s_axis_tlast  <= row_end;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(pixel, row_end);
    endtask

    task automatic send_row(input int len);
        for (int k = 0; k < len; k++)
            send_pixel(random_pixel(), k == len - 1);
    endtask

    // Random rows, mostly short, until the pixel budget is spent.
    task automatic send_rows(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 1);
            send_row(len);
            sent += len;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_weight(index, value);
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [1:0] index);
        logic [31:0] want;
        want    = sb.weight_of(index);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t ns: register %0d expected %0h actual %0h", $time, index, want,
                     prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load all three weights while the block is idle, with junk in the upper half.
    task automatic set_weights(input logic [15:0] outer, inner, center);
        wait_drained();
        apb_write(REG_OUTER,  {16'($urandom_range(65535)), outer});
        apb_write(REG_INNER,  {16'($urandom_range(65535)), inner});
        apb_write(REG_CENTER, {16'($urandom_range(65535)), center});
        apb_write(REG_UNUSED, 32'($urandom_range(65535)));
        apb_read(REG_OUTER);
        apb_read(REG_INNER);
        apb_read(REG_CENTER);
    endtask

    initial begin
        int n;
        logic [15:0] outer;
        logic [15:0] inner;

        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows of one to six pixels at the reset weights.
        n = 0;
        for (int len = 0; len <= 6; len++) begin
            for (int k = 0; k < ((len == 0) ? 1 : len); k++) begin
                send_pixel(corner_pixel(n), k == ((len == 0) ? 0 : len - 1));
                n++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Full-scale weights saturate; slow receiver.
        set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 25;
        recv_idle_pct = 84;
        send_rows(450);

        // All weights zero.
        set_weights(16'h0000, 16'h0000, 16'h0000);
        send_rows(60);

        // Random weights; slow sender.
        set_weights(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(65535)));
        send_idle_pct = 84;
        recv_idle_pct = 25;
        send_rows(450);

        // Gaussian-like weights near unity gain, no idling, long output stalls.
        outer = 16'($urandom_range(3000));
        inner = 16'($urandom_range(16000, 8000));
        set_weights(outer, inner, 16'(32'd65536 - 2 * outer - 2 * inner
                                      + $urandom_range(600) - 300));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        send_rows(400);
        hold_asked++;
        send_rows(400);

        wait_drained();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
design/lgd_pkg.sv
design/lgd_front.sv
design/lgd_fifo.sv
design/lgd_back.sv
design/luma_gauss_decimate_row.sv
sim/luma_gauss_decimate_row_test.sv
